// ===== hdl/dftm_pkg.sv =====
`timescale 1ns / 1ps

package dftm_pkg;

   localparam int IN_DATA_W  = 152;
   localparam int OUT_DATA_W = 56;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 48;
   localparam int OUT_CNT_W  = 5;

   localparam logic [CSR_ADDR_W-1:0] CSR_OUR_BSSID      = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BSSID_KNOWN    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOG_THROTTLE   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RECENT_WINDOW  = 2'd3;

   localparam logic [11:0] MIN_FRAME_LEN  = 12'd26;
   localparam logic [1:0]  TYPE_MGMT      = 2'd0;
   localparam logic [3:0]  SUBTYPE_DEAUTH = 4'd12;
   localparam logic [3:0]  SUBTYPE_DISAS  = 4'd10;
   localparam logic [31:0] AGE_HOT_MS     = 32'd1000;
   localparam logic [31:0] AGE_WARM_MS    = 32'd5000;
   localparam logic [31:0] AGE_COOL_MS    = 32'd30000;
   localparam logic [31:0] VOLUME_MS      = 32'd10000;
   localparam logic [6:0]  ATTACK_SCORE   = 7'd70;
   localparam logic [6:0]  SCORE_CAP      = 7'd100;
   localparam logic [6:0]  PTS_VOL_HIGH   = 7'd40;
   localparam logic [6:0]  PTS_VOL_MID    = 7'd25;
   localparam logic [6:0]  PTS_VOL_LOW    = 7'd10;
   localparam logic [6:0]  PTS_TARGETED   = 7'd30;
   localparam logic [4:0]  PTS_REC_HOT    = 5'd30;
   localparam logic [4:0]  PTS_REC_WARM   = 5'd20;
   localparam logic [4:0]  PTS_REC_COOL   = 5'd10;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [47:0] our_bssid;
      logic        bssid_known;
      logic [15:0] throttle_ms;
      logic [31:0] recent_window_ms;
   } cfg_type;

   typedef struct packed {
      logic        counted;
      logic        logged;
      logic        disassoc;
      logic        targeted;
      logic        total_zero;
      logic [4:0]  rec_pts;
      logic [31:0] total;
      logic [31:0] now_ms;
      logic [47:0] source_mac;
   } work_type;

endpackage

// ===== hdl/deauth_frame_threat_monitor.sv =====
`timescale 1ns / 1ps

// channel  dir  handshake          payload
// req      in   tvalid/tready      tdata frame summary, tuser action
// rsp      out  tvalid/tready      tdata scores and flags
// csr      in   we                 addr, wdata (no read-back)
//
// Each request passes through the log walker, which visits at most LOG_DEPTH entries;
// the single read port of the log memory walks one entry a cycle.
// The front classifies and keeps counters; a 2-deep queue feeds the walker.
// Reset is synchronous; the log holds nothing after reset.
// rsp stalls hold the walker only at its final step; the front keeps taking
// requests until the queue fills.

module deauth_frame_threat_monitor #(
   parameter int LOG_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // is_management, frame_control, frame_length, source_mac, frame_bssid, now_ms
   input  logic [dftm_pkg::IN_DATA_W-1:0]      req_tdata,
   // action
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // frame_counted, frame_logged, is_disassoc, is_targeted, total_frames,
   // recent_count, threat_score, under_attack, unique_sources
   output logic [dftm_pkg::OUT_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [dftm_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [dftm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   dftm_pkg::cfg_type  cfg_ff;
   dftm_pkg::work_type push_item, pop_item;
   logic q_full, q_push, q_pop, q_not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.our_bssid        <= 48'd0;
         cfg_ff.bssid_known      <= 1'b0;
         cfg_ff.throttle_ms      <= 16'd500;
         cfg_ff.recent_window_ms <= 32'd10000;
      end else if (csr_we) begin
         case (csr_addr)
            dftm_pkg::CSR_OUR_BSSID:     cfg_ff.our_bssid        <= csr_wdata;
            dftm_pkg::CSR_BSSID_KNOWN:   cfg_ff.bssid_known      <= csr_wdata[0];
            dftm_pkg::CSR_LOG_THROTTLE:  cfg_ff.throttle_ms      <= csr_wdata[15:0];
            dftm_pkg::CSR_RECENT_WINDOW: cfg_ff.recent_window_ms <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   dftm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   dftm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_item  (pop_item)
   );

   dftm_back #(
      .LOG_DEPTH (LOG_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .recent_window_ms (cfg_ff.recent_window_ms),
      .q_not_empty      (q_not_empty),
      .q_item           (pop_item),
      .q_pop            (q_pop),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata)
   );

   a_logged_is_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1]) |-> (rsp_tdata[0] && (rsp_tdata[53:49] != 5'd0)))
      else $error("logged response without counted frame or sources");

   a_zero_total_zero_score: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[35:4] == 32'd0)) |-> (rsp_tdata[47:41] == 7'd0))
      else $error("nonzero score with zero total");

   a_attack_needs_score: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[48]) |-> (rsp_tdata[47:41] >= dftm_pkg::ATTACK_SCORE))
      else $error("under_attack below threshold");

endmodule

// ===== hdl/dftm_front.sv =====
`timescale 1ns / 1ps

module dftm_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [dftm_pkg::IN_DATA_W-1:0]     req_tdata,
   input  logic                               req_tuser,
   input  dftm_pkg::cfg_type                  cfg,
   input  logic                               q_full,
   output logic                               q_push,
   output dftm_pkg::work_type                 q_item
);

   logic        phase_ff, phase_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] last_frame_ff, last_frame_in;
   logic [31:0] last_log_ff, last_log_in;

   logic        is_mgmt;
   logic [7:0]  fc;
   logic [11:0] flen;
   logic [47:0] src;
   logic [47:0] bss;
   logic [31:0] now;
   logic        examine, hit, pass_throttle;
   logic [31:0] since;

   assign is_mgmt = req_tdata[0];
   assign fc      = req_tdata[8:1];
   assign flen    = req_tdata[20:9];
   assign src     = req_tdata[68:21];
   assign bss     = req_tdata[116:69];
   assign now     = req_tdata[148:117];

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      examine = !req_tuser && is_mgmt;
      phase_in = examine ? !phase_ff : phase_ff;
      hit = examine && phase_ff && (flen >= dftm_pkg::MIN_FRAME_LEN)
            && (fc[3:2] == dftm_pkg::TYPE_MGMT)
            && ((fc[7:4] == dftm_pkg::SUBTYPE_DEAUTH) || (fc[7:4] == dftm_pkg::SUBTYPE_DISAS));
      pass_throttle = (now - last_log_ff) >= {16'd0, cfg.throttle_ms};
      total_in      = hit ? total_ff + 32'd1 : total_ff;
      last_frame_in = hit ? now : last_frame_ff;
      last_log_in   = (hit && pass_throttle) ? now : last_log_ff;
      since         = now - last_frame_in;

      q_item.counted    = hit;
      q_item.logged     = hit && pass_throttle;
      q_item.disassoc   = hit && (fc[7:4] == dftm_pkg::SUBTYPE_DISAS);
      q_item.targeted   = hit && cfg.bssid_known && (bss == cfg.our_bssid);
      q_item.total_zero = (total_in == 32'd0);
      q_item.total      = total_in;
      q_item.now_ms     = now;
      q_item.source_mac = src;
      if (since < dftm_pkg::AGE_HOT_MS) begin
         q_item.rec_pts = dftm_pkg::PTS_REC_HOT;
      end else if (since < dftm_pkg::AGE_WARM_MS) begin
         q_item.rec_pts = dftm_pkg::PTS_REC_WARM;
      end else if (since < dftm_pkg::AGE_COOL_MS) begin
         q_item.rec_pts = dftm_pkg::PTS_REC_COOL;
      end else begin
         q_item.rec_pts = 5'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= 1'b0;
         total_ff      <= 32'd0;
         last_frame_ff <= 32'd0;
         last_log_ff   <= 32'd0;
      end else if (q_push) begin
         phase_ff      <= phase_in;
         total_ff      <= total_in;
         last_frame_ff <= last_frame_in;
         last_log_ff   <= last_log_in;
      end
   end

endmodule

// ===== hdl/dftm_queue.sv =====
`timescale 1ns / 1ps

module dftm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dftm_pkg::work_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output dftm_pkg::work_type pop_item
);

   localparam int PW = $clog2(dftm_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(dftm_pkg::QUEUE_DEPTH + 1);

   dftm_pkg::work_type slot_ff [dftm_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] cnt_ff;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(dftm_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign full      = (cnt_ff == CW'(dftm_pkg::QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_item  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= bump(wr_ff);
         end
         if (pop) begin
            rd_ff <= bump(rd_ff);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + CW'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

endmodule

// ===== hdl/dftm_back.sv =====
`timescale 1ns / 1ps

module dftm_back #(
   parameter int LOG_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [31:0]                       recent_window_ms,
   input  logic                              q_not_empty,
   input  dftm_pkg::work_type                q_item,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dftm_pkg::OUT_DATA_W-1:0]   rsp_tdata
);

   localparam int PTR_W = $clog2(LOG_DEPTH);
   localparam int CNT_W = $clog2(LOG_DEPTH + 1);
   localparam int ENT_W = 81;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [ENT_W-1:0] log_mem [LOG_DEPTH];
   logic [ENT_W-1:0] rd_q;
   logic             mem_we;
   logic [PTR_W-1:0] mem_wa;
   logic [ENT_W-1:0] mem_wd;

   logic [1:0]       state_ff, state_in;
   dftm_pkg::work_type item_ff, item_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic             pend_ff, pend_in;
   logic [PTR_W-1:0] pend_ptr_ff, pend_ptr_in;
   logic [CNT_W-1:0] recent_ff, recent_in;
   logic [CNT_W-1:0] vol_ff, vol_in;
   logic [CNT_W-1:0] uniq_ff, uniq_in;
   logic             tgt_ff, tgt_in;
   logic [LOG_DEPTH-1:0] later_ff, later_in;
   logic             out_valid_ff, out_valid_in;
   logic [dftm_pkg::OUT_DATA_W-1:0] out_data_ff, out_data_in;

   logic             skip;
   logic [PTR_W:0]   slot_sum;
   logic [PTR_W-1:0] slot;
   logic [31:0]      age;
   logic             match;
   logic [CNT_W-1:0] add_new;
   logic [CNT_W-1:0] fin_recent, fin_vol, fin_uniq;
   logic             fin_tgt;
   logic [6:0]       vol_pts, score;
   logic [7:0]       raw_score;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(LOG_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         log_mem[mem_wa] <= mem_wd;
      end
      rd_q <= log_mem[rd_ptr_ff];
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      fill_in      = fill_ff;
      head_in      = head_ff;
      rd_ptr_in    = rd_ptr_ff;
      remain_in    = remain_ff;
      pend_in      = 1'b0;
      pend_ptr_in  = rd_ptr_ff;
      recent_in    = recent_ff;
      vol_in       = vol_ff;
      uniq_in      = uniq_ff;
      tgt_in       = tgt_ff;
      later_in     = later_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_wd       = {item_ff.targeted, item_ff.source_mac, item_ff.now_ms};

      skip     = q_item.logged && (fill_ff == CNT_W'(LOG_DEPTH));
      slot_sum = {1'b0, head_ff} + {1'b0, fill_ff[PTR_W-1:0]};
      if (fill_ff == CNT_W'(LOG_DEPTH)) begin
         slot = head_ff;
      end else if (slot_sum >= (PTR_W+1)'(LOG_DEPTH)) begin
         slot = PTR_W'(slot_sum - (PTR_W+1)'(LOG_DEPTH));
      end else begin
         slot = slot_sum[PTR_W-1:0];
      end
      mem_wa = slot;

      age   = item_ff.now_ms - rd_q[31:0];
      match = item_ff.logged && (rd_q[79:32] == item_ff.source_mac);

      add_new    = item_ff.logged ? CNT_W'(1) : '0;
      fin_recent = recent_ff + add_new;
      fin_vol    = vol_ff + add_new;
      fin_uniq   = uniq_ff + add_new;
      fin_tgt    = tgt_ff || (item_ff.logged && item_ff.targeted);
      if (7'(fin_vol) >= 7'd10) begin
         vol_pts = dftm_pkg::PTS_VOL_HIGH;
      end else if (7'(fin_vol) >= 7'd5) begin
         vol_pts = dftm_pkg::PTS_VOL_MID;
      end else if (7'(fin_vol) >= 7'd2) begin
         vol_pts = dftm_pkg::PTS_VOL_LOW;
      end else begin
         vol_pts = 7'd0;
      end
      raw_score = {3'd0, item_ff.rec_pts} + {1'b0, vol_pts}
                  + (fin_tgt ? {1'b0, dftm_pkg::PTS_TARGETED} : 8'd0);
      if (item_ff.total_zero) begin
         score = 7'd0;
      end else if (raw_score > {1'b0, dftm_pkg::SCORE_CAP}) begin
         score = dftm_pkg::SCORE_CAP;
      end else begin
         score = raw_score[6:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               q_pop     = 1'b1;
               item_in   = q_item;
               rd_ptr_in = skip ? bump(head_ff) : head_ff;
               remain_in = fill_ff - (skip ? CNT_W'(1) : '0);
               recent_in = '0;
               vol_in    = '0;
               uniq_in   = '0;
               tgt_in    = 1'b0;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            if (remain_ff != '0) begin
               pend_in   = 1'b1;
               rd_ptr_in = bump(rd_ptr_ff);
               remain_in = remain_ff - CNT_W'(1);
            end else if (!pend_ff) begin
               state_in = ST_FINISH;
            end
            if (pend_ff) begin
               if (age <= recent_window_ms) begin
                  recent_in = recent_ff + CNT_W'(1);
               end
               if (age <= dftm_pkg::VOLUME_MS) begin
                  vol_in = vol_ff + CNT_W'(1);
               end
               if (rd_q[80]) begin
                  tgt_in = 1'b1;
               end
               if (!(later_ff[pend_ptr_ff] || match)) begin
                  uniq_in = uniq_ff + CNT_W'(1);
               end
               if (match) begin
                  later_in[pend_ptr_ff] = 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_data_in  = {2'b00,
                               dftm_pkg::OUT_CNT_W'(fin_uniq),
                               (score >= dftm_pkg::ATTACK_SCORE) && fin_tgt,
                               score,
                               dftm_pkg::OUT_CNT_W'(fin_recent),
                               item_ff.total,
                               item_ff.targeted,
                               item_ff.disassoc,
                               item_ff.logged,
                               item_ff.counted};
               if (item_ff.logged) begin
                  mem_we         = 1'b1;
                  later_in[slot] = 1'b0;
                  if (fill_ff == CNT_W'(LOG_DEPTH)) begin
                     head_in = bump(head_ff);
                  end else begin
                     fill_in = fill_ff + CNT_W'(1);
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         head_ff      <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         later_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
         later_ff     <= later_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rd_ptr_ff   <= rd_ptr_in;
      remain_ff   <= remain_in;
      pend_ptr_ff <= pend_ptr_in;
      recent_ff   <= recent_in;
      vol_ff      <= vol_in;
      uniq_ff     <= uniq_in;
      tgt_ff      <= tgt_in;
      out_data_ff <= out_data_in;
   end

endmodule

// ===== test/dftm_checker.sv =====
`timescale 1ns / 1ps

module dftm_checker #(
   parameter int LOG_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [dftm_pkg::IN_DATA_W-1:0]      req_tdata,
   input  logic                                req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [dftm_pkg::OUT_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [dftm_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [dftm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                  errors,
   output int                                  pending,
   output int                                  counted_seen,
   output int                                  logged_seen,
   output int                                  attack_seen
);

   typedef struct packed {
      logic        counted;
      logic        logged;
      logic        disassoc;
      logic        targeted;
      logic [31:0] total;
      logic [4:0]  recent;
      logic [6:0]  score;
      logic        attack;
      logic [4:0]  uniq;
   } verdict_type;

   dftm_pkg::cfg_type cfg;
   logic        phase;
   logic [31:0] total_count;
   logic [31:0] last_frame;
   logic [31:0] last_log;
   int          fill;
   logic [31:0] log_t[LOG_DEPTH];
   logic [47:0] log_src[LOG_DEPTH];
   logic        log_tgt[LOG_DEPTH];
   verdict_type verdicts[$];

   assign pending = verdicts.size();

   function automatic int aged_within(logic [31:0] now, logic [31:0] win);
      int n;
      n = 0;
      for (int i = 0; i < fill; i++)
         if (32'(now - log_t[i]) <= win) n++;
      return n;
   endfunction

   function automatic logic any_tgt();
      for (int i = 0; i < fill; i++)
         if (log_tgt[i]) return 1'b1;
      return 1'b0;
   endfunction

   function automatic verdict_type assess(logic is_tick,
                                          logic [dftm_pkg::IN_DATA_W-1:0] d);
      verdict_type v;
      logic        mgmt;
      logic [7:0]  fc;
      logic [11:0] len;
      logic [47:0] src, bss;
      logic [31:0] now, since;
      int          s, vol, n;
      logic        dup;
      mgmt = d[0];
      fc   = d[8:1];
      len  = d[20:9];
      src  = d[68:21];
      bss  = d[116:69];
      now  = d[148:117];
      v = '0;
      if (!is_tick && mgmt) begin
         phase = ~phase;
         if (!phase && len >= dftm_pkg::MIN_FRAME_LEN && fc[3:2] == dftm_pkg::TYPE_MGMT &&
             (fc[7:4] == dftm_pkg::SUBTYPE_DEAUTH || fc[7:4] == dftm_pkg::SUBTYPE_DISAS)) begin
            v.counted  = 1'b1;
            v.disassoc = fc[7:4] == dftm_pkg::SUBTYPE_DISAS;
            v.targeted = cfg.bssid_known && bss == cfg.our_bssid;
            total_count++;
            last_frame = now;
            if (32'(now - last_log) >= {16'd0, cfg.throttle_ms}) begin
               v.logged = 1'b1;
               last_log = now;
               if (fill >= LOG_DEPTH) begin
                  for (int i = 0; i + 1 < LOG_DEPTH; i++) begin
                     log_t[i]   = log_t[i+1];
                     log_src[i] = log_src[i+1];
                     log_tgt[i] = log_tgt[i+1];
                  end
                  fill = LOG_DEPTH - 1;
               end
               log_t[fill]   = now;
               log_src[fill] = src;
               log_tgt[fill] = v.targeted;
               fill++;
            end
         end
      end
      s = 0;
      if (total_count != 0) begin
         since = now - last_frame;
         if (since < dftm_pkg::AGE_HOT_MS) s += dftm_pkg::PTS_REC_HOT;
         else if (since < dftm_pkg::AGE_WARM_MS) s += dftm_pkg::PTS_REC_WARM;
         else if (since < dftm_pkg::AGE_COOL_MS) s += dftm_pkg::PTS_REC_COOL;
         vol = aged_within(now, dftm_pkg::VOLUME_MS);
         if (vol >= 10) s += dftm_pkg::PTS_VOL_HIGH;
         else if (vol >= 5) s += dftm_pkg::PTS_VOL_MID;
         else if (vol >= 2) s += dftm_pkg::PTS_VOL_LOW;
         if (any_tgt()) s += dftm_pkg::PTS_TARGETED;
         if (s > dftm_pkg::SCORE_CAP) s = dftm_pkg::SCORE_CAP;
      end
      n = 0;
      for (int i = 0; i < fill; i++) begin
         dup = 1'b0;
         for (int j = 0; j < i; j++)
            if (log_src[j] == log_src[i]) dup = 1'b1;
         if (!dup) n++;
      end
      v.total  = total_count;
      v.recent = 5'(aged_within(now, cfg.recent_window_ms));
      v.score  = 7'(s);
      v.attack = s >= dftm_pkg::ATTACK_SCORE && any_tgt();
      v.uniq   = 5'(n);
      return v;
   endfunction

   task automatic check_field(string name, longint e, longint a);
      if (e != a) begin
         $error("%s: expected %0d, got %0d", name, e, a);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      verdict_type e, a;
      if (reset) begin
         cfg <= '{our_bssid: '0, bssid_known: 1'b0, throttle_ms: 16'd500,
                  recent_window_ms: 32'd10000};
         phase = 1'b0;
         total_count = '0;
         last_frame = '0;
         last_log = '0;
         fill = 0;
         verdicts.delete();
         errors = 0;
         counted_seen = 0;
         logged_seen = 0;
         attack_seen = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               dftm_pkg::CSR_OUR_BSSID:     cfg.our_bssid <= csr_wdata;
               dftm_pkg::CSR_BSSID_KNOWN:   cfg.bssid_known <= csr_wdata[0];
               dftm_pkg::CSR_LOG_THROTTLE:  cfg.throttle_ms <= csr_wdata[15:0];
               dftm_pkg::CSR_RECENT_WINDOW: cfg.recent_window_ms <= csr_wdata[31:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) verdicts.push_back(assess(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            a = {rsp_tdata[0], rsp_tdata[1], rsp_tdata[2], rsp_tdata[3],
                 rsp_tdata[35:4], rsp_tdata[40:36], rsp_tdata[47:41],
                 rsp_tdata[48], rsp_tdata[53:49]};
            if (verdicts.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               e = verdicts.pop_front();
               check_field("frame_counted", e.counted, a.counted);
               check_field("frame_logged", e.logged, a.logged);
               check_field("is_disassoc", e.disassoc, a.disassoc);
               check_field("is_targeted", e.targeted, a.targeted);
               check_field("total_frames", e.total, a.total);
               check_field("recent_count", e.recent, a.recent);
               check_field("threat_score", e.score, a.score);
               check_field("under_attack", e.attack, a.attack);
               check_field("unique_sources", e.uniq, a.uniq);
               counted_seen += e.counted;
               logged_seen += e.logged;
               attack_seen += e.attack;
            end
         end
      end
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam logic ACT_FRAME = 1'b0;
   localparam logic ACT_TICK  = 1'b1;
   localparam logic [7:0] FC_DEAUTH = {dftm_pkg::SUBTYPE_DEAUTH, dftm_pkg::TYPE_MGMT, 2'b00};
   localparam logic [7:0] FC_DISAS  = {dftm_pkg::SUBTYPE_DISAS, dftm_pkg::TYPE_MGMT, 2'b00};

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [dftm_pkg::IN_DATA_W-1:0]  req_tdata;
   logic                            req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [dftm_pkg::OUT_DATA_W-1:0] rsp_tdata;
   logic                            csr_we;
   logic [dftm_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [dftm_pkg::CSR_DATA_W-1:0] csr_wdata;
   int                    errors, pending, counted_seen, logged_seen, attack_seen;
   int                    sent, hold;
   logic                  calm;
   logic [31:0]           clk_ms;
   logic [47:0]           ours;
   logic [47:0]           pool[6];

   deauth_frame_threat_monitor dut (.*);

   dftm_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("[deauth_frame_threat_monitor] ERROR");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold <= 0;
      end else if (hold > 0) begin
         hold <= hold - 1;
         rsp_tready <= 1'b0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
         hold <= $urandom_range(10, 40);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(0, 99) < 70;
      end
   end

   task automatic push(logic act, logic mgmt, logic [7:0] fc, logic [11:0] len,
                       logic [47:0] src, logic [47:0] bss, logic [31:0] now);
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {3'b0, now, bss, src, len, fc, mgmt};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      sent++;
   endtask

   task automatic write_reg(logic [dftm_pkg::CSR_ADDR_W-1:0] a,
                            logic [dftm_pkg::CSR_DATA_W-1:0] v);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= a;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [47:0] rand_mac();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // mostly well-formed deauth/disassoc bursts over a small set of senders
   task automatic random_run(int n, int step_max);
      int          r;
      logic [7:0]  fc;
      logic [11:0] len;
      logic [47:0] src, bss;
      for (int i = 0; i < n; i++) begin
         if (i % 60 == 0) calm = $urandom_range(0, 3) == 0;
         r = $urandom_range(0, 99);
         if (r < 3) clk_ms += $urandom_range(20000, 40000);
         else clk_ms += $urandom_range(0, step_max);
         fc  = $urandom_range(0, 1) ? FC_DEAUTH : FC_DISAS;
         len = $urandom_range(26, 200);
         src = pool[$urandom_range(0, 5)];
         bss = $urandom_range(0, 1) ? ours : rand_mac();
         r = $urandom_range(0, 99);
         if (r < 8) begin
            push(ACT_TICK, 1'($urandom), 8'($urandom), 12'($urandom), rand_mac(),
                 rand_mac(), clk_ms);
         end else if (r < 14) begin
            push(ACT_FRAME, 1'($urandom), 8'($urandom), 12'($urandom), rand_mac(),
                 rand_mac(), clk_ms);
         end else begin
            if (r < 18) len = $urandom_range(0, 27);
            if (r < 20) src = rand_mac();
            push(ACT_FRAME, 1'b1, fc, len, src, bss, clk_ms);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = ACT_FRAME;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = dftm_pkg::CSR_OUR_BSSID;
      csr_wdata = '0;
      calm = 1'b0;
      sent = 0;
      ours = 48'h0;
      clk_ms = 32'd10;
      for (int i = 0; i < 6; i++) pool[i] = rand_mac();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: early throttled frame, length edge, types, ticks, extremes
      push(ACT_TICK, 1'b0, 8'h00, 12'h000, 48'h0, 48'h0, 32'd0);
      push(ACT_FRAME, 1'b1, FC_DEAUTH, 12'd26, pool[0], ours, clk_ms);
      push(ACT_FRAME, 1'b1, FC_DEAUTH, 12'd26, pool[0], ours, clk_ms);
      clk_ms = 32'd600;
      push(ACT_FRAME, 1'b1, FC_DISAS, 12'd25, pool[1], ours, clk_ms);
      push(ACT_FRAME, 1'b1, FC_DISAS, 12'd25, pool[1], ours, clk_ms);
      push(ACT_FRAME, 1'b1, FC_DISAS, 12'hFFF, pool[1], ours, clk_ms);
      push(ACT_FRAME, 1'b1, FC_DISAS, 12'hFFF, '1, '1, clk_ms);
      push(ACT_FRAME, 1'b1, 8'hC4, 12'd60, pool[2], ours, clk_ms);
      push(ACT_FRAME, 1'b1, 8'hC4, 12'd60, pool[2], ours, clk_ms);
      push(ACT_FRAME, 1'b1, 8'hB0, 12'd60, pool[2], ours, clk_ms);
      push(ACT_FRAME, 1'b1, 8'hB3, 12'd60, pool[2], ours, clk_ms);
      push(ACT_FRAME, 1'b0, FC_DEAUTH, 12'd60, pool[3], ours, clk_ms);
      push(ACT_TICK, 1'b1, '1, '1, '1, '1, '1);
      push(ACT_TICK, 1'b1, FC_DEAUTH, 12'd60, pool[3], ours, 32'd700);

      write_reg(dftm_pkg::CSR_OUR_BSSID, 48'hFFFF_FFFF_FFFF);
      write_reg(dftm_pkg::CSR_BSSID_KNOWN, 48'd1);
      write_reg(dftm_pkg::CSR_LOG_THROTTLE, 48'd0);
      write_reg(dftm_pkg::CSR_RECENT_WINDOW, 48'd0);
      ours = 48'hFFFF_FFFF_FFFF;
      random_run(360, 400);

      ours = rand_mac();
      write_reg(dftm_pkg::CSR_OUR_BSSID, ours);
      write_reg(dftm_pkg::CSR_LOG_THROTTLE, 48'hFFFF);
      write_reg(dftm_pkg::CSR_RECENT_WINDOW, 48'hFFFF_FFFF);
      random_run(300, 30000);

      write_reg(dftm_pkg::CSR_LOG_THROTTLE, 48'd300);
      write_reg(dftm_pkg::CSR_RECENT_WINDOW, 48'd4000);
      clk_ms = 32'hFFFF_F000;
      random_run(400, 700);

      ours = 48'h0;
      write_reg(dftm_pkg::CSR_BSSID_KNOWN, 48'd0);
      write_reg(dftm_pkg::CSR_OUR_BSSID, 48'h0);
      write_reg(dftm_pkg::CSR_LOG_THROTTLE, 48'd50);
      write_reg(dftm_pkg::CSR_RECENT_WINDOW, 48'd10000);
      random_run(380, 250);

      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("requests %0d: %0d counted, %0d logged, %0d under attack",
               sent, counted_seen, logged_seen, attack_seen);
      $display("four register settings incl. zero and full-scale throttle/window, time wrap");
      if (errors == 0) $display("[deauth_frame_threat_monitor] OK");
      else $display("[deauth_frame_threat_monitor] ERROR");
      $finish;
   end

endmodule
